/* src/fspa_pkg.sv */
// Package for the fixed slot pool allocator: field widths, reset values,
// op/status/register codes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package fspa_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int FREE_W     = 9;
    localparam int OBJ_W      = 16;
    localparam int ALIGN_W    = 13;
    localparam int COUNT_W    = 9;
    localparam int SLOT_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int DEF_MAX_SLOTS      = 256;
    localparam int DEF_MIN_SLOT_BYTES = 8;
    localparam int DEF_ADDRESS_BITS   = 32;

    // register reset values
    localparam int RST_BASE  = 4096;
    localparam int RST_OBJ   = 16;
    localparam int RST_ALIGN = 8;
    localparam int RST_COUNT = 256;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EXHAUSTED   = 3'd1,
        ST_OUT_OF_POOL = 3'd2,
        ST_MISALIGNED  = 3'd3,
        ST_NULL        = 3'd4,
        ST_DOUBLE_FREE = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_OBJ   = 2'd1,
        CFG_ALIGN = 2'd2,
        CFG_COUNT = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_CHK,
        S_FREE_DIV,
        S_REB_DIV,
        S_REB_MUL
    } t_state;

endpackage

/* src/fixed_slot_pool_allocator.sv */
// Fixed slot pool allocator top level: controller, config registers, address math.
// Uses fspa_pkg, fspa_ram (free stack) and fspa_div (slot size / free index).
`timescale 1ns / 1ps

// Usage
//   Command channel: a word is taken at a rising edge with start high and busy
//   low. op selects allocate, free (i_free_address), rebuild, or no-op.
//   Result channel: exactly one result word per command, shown for a single
//   cycle with o_strobe high. The receiver cannot stall; it must take it.
//   Config port: i_cfg_we/i_cfg_addr/i_cfg_data write base, object size,
//   alignment, slot count. Size and count take effect at the next rebuild;
//   the base address is used live. Write only while busy is low.
// Steps per command, one command in flight at a time:
//   allocate: stack read, index * slot size, add base;
//   exhausted / null free / no-op: answered straight from idle;
//   free: pool-bounds check, then, when in the pool, a divide of the offset
//   by the slot size on the bit-serial divider;
//   rebuild: a divide of size by alignment unless the alignment is zero, then a multiply.
//   busy drops in the strobe cycle, so the next command may be issued then.
// Reset: synchronous, active low. It loads the register defaults and a built
//   free list directly; there is no clearing pass. Stack entries below a
//   low-water mark read back as their own index, so the RAM never needs a fill.
module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int MAX_SLOTS      = DEF_MAX_SLOTS,
    parameter int MIN_SLOT_BYTES = DEF_MIN_SLOT_BYTES,
    parameter int ADDRESS_BITS   = DEF_ADDRESS_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [ADDR_W-1:0]     i_free_address,
    output logic                  o_strobe,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDR_W-1:0]     o_slot_address,
    output logic [FREE_W-1:0]     o_free_slots,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sizes derived from the pool depth
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int TOT_W  = SLOT_W + CNT_W;
    localparam int PROD_W = SLOT_W + IDX_W;
    localparam int CMP_W  = (TOT_W > ADDR_W) ? TOT_W : ADDR_W;
    localparam int NUM_W  = SLOT_W + IDX_W;
    localparam int Q_W    = (OBJ_W > IDX_W) ? OBJ_W : IDX_W;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_W) ? '1 :
        ADDR_W'((64'(1) << ADDRESS_BITS) - 64'(1));

    // free list as built from the reset registers
    localparam int RST_MIN    = (RST_OBJ > MIN_SLOT_BYTES) ? RST_OBJ : MIN_SLOT_BYTES;
    localparam int RST_AL_NZ  = (RST_ALIGN == 0) ? 1 : RST_ALIGN;
    localparam int RST_SLOT   = (RST_ALIGN == 0 || (RST_MIN % RST_AL_NZ) == 0) ? RST_MIN :
                                RST_MIN + RST_AL_NZ - (RST_MIN % RST_AL_NZ);
    localparam int RST_ACTIVE = (RST_COUNT > MAX_SLOTS) ? MAX_SLOTS : RST_COUNT;
    localparam int RST_TOTAL  = RST_SLOT * RST_ACTIVE;

    // config registers
    logic [ADDR_W-1:0]  r_base;
    logic [OBJ_W-1:0]   r_obj;
    logic [ALIGN_W-1:0] r_align;
    logic [COUNT_W-1:0] r_count;

    // allocator state
    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_top,    n_top;      // free-stack depth
    logic [CNT_W-1:0]   r_lw,     n_lw;       // entries below this were never pushed
    logic [CNT_W-1:0]   r_active, n_active;   // slot count latched at rebuild
    logic [SLOT_W-1:0]  r_slot,   n_slot;
    logic [TOT_W-1:0]   r_total,  n_total;    // pool bytes, slot * active

    // working registers
    logic [ADDR_W-1:0]  r_in_addr;
    logic [IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [PROD_W-1:0]  r_prod,   n_prod;

    // result registers
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic [ADDR_W-1:0]  r_addr_out, n_addr_out;
    logic [FREE_W-1:0]  r_free_out, n_free_out;

    // stack RAM and divider hookup
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [IDX_W-1:0]   ram_rdata;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [SLOT_W-1:0]  div_den;
    logic               div_done;
    logic [Q_W-1:0]     div_quo;
    logic [SLOT_W-1:0]  div_rem;

    logic               accept;
    logic [SLOT_W-1:0]  obj_min;
    logic [CNT_W-1:0]   count_cap;
    logic               addr_below;
    logic [CMP_W-1:0]   off_ext;
    logic [IDX_W-1:0]   pop_idx;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // object size raised to the minimum slot size
    assign obj_min   = (SLOT_W'(r_obj) > SLOT_W'(MIN_SLOT_BYTES)) ? SLOT_W'(r_obj) :
                       SLOT_W'(MIN_SLOT_BYTES);
    assign count_cap = (32'(r_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_count);

    assign addr_below = (r_in_addr < r_base);
    assign off_ext    = CMP_W'(r_in_addr - r_base);

    // entry never pushed since the rebuild still holds its own index
    assign pop_idx = (CNT_W'(r_rd_idx) < r_lw) ? r_rd_idx : ram_rdata;

    fspa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fspa_div #(
        .NUM_W (NUM_W),
        .DEN_W (SLOT_W),
        .Q_W   (Q_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // rebuild divides size by alignment from idle; free divides the offset
    assign div_num = (r_state == S_IDLE) ? NUM_W'(obj_min) : NUM_W'(off_ext);
    assign div_den = (r_state == S_IDLE) ? SLOT_W'(r_align) : r_slot;

    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_lw       = r_lw;
        n_active   = r_active;
        n_slot     = r_slot;
        n_total    = r_total;
        n_rd_idx   = r_rd_idx;
        n_prod     = r_prod;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_addr_out = r_addr_out;
        n_free_out = r_free_out;
        ram_we     = 1'b0;
        ram_waddr  = IDX_W'(r_top);
        ram_wdata  = div_quo[IDX_W-1:0];
        ram_raddr  = IDX_W'(r_top - 1'b1);
        div_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_op))
                        OP_ALLOC: begin
                            if (r_top == '0) begin
                                n_strobe   = 1'b1;
                                n_status   = ST_EXHAUSTED;
                                n_addr_out = '0;
                                n_free_out = FREE_W'(r_top);
                            end else begin
                                n_top    = r_top - 1'b1;
                                n_rd_idx = IDX_W'(r_top - 1'b1);
                                n_state  = S_ALLOC_MUL;
                            end
                        end
                        OP_FREE: begin
                            if (i_free_address == '0) begin
                                n_strobe   = 1'b1;
                                n_status   = ST_NULL;
                                n_addr_out = '0;
                                n_free_out = FREE_W'(r_top);
                            end else begin
                                n_state = S_FREE_CHK;
                            end
                        end
                        OP_REBUILD: begin
                            n_active = count_cap;
                            if (r_align == '0) begin
                                n_slot  = obj_min;
                                n_state = S_REB_MUL;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_REB_DIV;
                            end
                        end
                        default: begin
                            n_strobe   = 1'b1;
                            n_status   = ST_OK;
                            n_addr_out = '0;
                            n_free_out = FREE_W'(r_top);
                        end
                    endcase
                end
            end
            S_ALLOC_MUL: begin
                n_prod  = PROD_W'(pop_idx) * PROD_W'(r_slot);
                n_state = S_ALLOC_ADD;
            end
            S_ALLOC_ADD: begin
                n_strobe   = 1'b1;
                n_status   = ST_OK;
                n_addr_out = (r_base + ADDR_W'(r_prod)) & ADDR_MASK;
                n_free_out = FREE_W'(r_top);
                n_state    = S_IDLE;
            end
            S_FREE_CHK: begin
                if (addr_below || off_ext >= CMP_W'(r_total)) begin
                    n_strobe   = 1'b1;
                    n_status   = ST_OUT_OF_POOL;
                    n_addr_out = '0;
                    n_free_out = FREE_W'(r_top);
                    n_state    = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_FREE_DIV;
                end
            end
            S_FREE_DIV: begin
                if (div_done) begin
                    n_strobe   = 1'b1;
                    n_addr_out = '0;
                    n_state    = S_IDLE;
                    if (div_rem != '0) begin
                        n_status = ST_MISALIGNED;
                    end else if (r_top >= r_active) begin
                        n_status = ST_DOUBLE_FREE;
                    end else begin
                        n_status = ST_OK;
                        ram_we   = 1'b1;
                        n_top    = r_top + 1'b1;
                        if (r_top < r_lw) begin
                            n_lw = r_top;
                        end
                    end
                    n_free_out = FREE_W'(n_top);
                end
            end
            S_REB_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_slot = obj_min;
                    end else begin
                        n_slot = obj_min + SLOT_W'(r_align) - div_rem;
                    end
                    n_state = S_REB_MUL;
                end
            end
            S_REB_MUL: begin
                n_total    = TOT_W'(r_slot) * TOT_W'(r_active);
                n_top      = r_active;
                n_lw       = r_active;
                n_strobe   = 1'b1;
                n_status   = ST_OK;
                n_addr_out = '0;
                n_free_out = FREE_W'(r_active);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= ADDR_W'(RST_BASE);
            r_obj    <= OBJ_W'(RST_OBJ);
            r_align  <= ALIGN_W'(RST_ALIGN);
            r_count  <= COUNT_W'(RST_COUNT);
            r_top    <= CNT_W'(RST_ACTIVE);
            r_lw     <= CNT_W'(RST_ACTIVE);
            r_active <= CNT_W'(RST_ACTIVE);
            r_slot   <= SLOT_W'(RST_SLOT);
            r_total  <= TOT_W'(RST_TOTAL);
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_BASE:  r_base  <= i_cfg_data[ADDR_W-1:0];
                    CFG_OBJ:   r_obj   <= i_cfg_data[OBJ_W-1:0];
                    CFG_ALIGN: r_align <= i_cfg_data[ALIGN_W-1:0];
                    CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                    default:   r_base  <= r_base;
                endcase
            end
            r_top    <= n_top;
            r_lw     <= n_lw;
            r_active <= n_active;
            r_slot   <= n_slot;
            r_total  <= n_total;
            r_strobe <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_addr <= i_free_address;
        end
        r_rd_idx   <= n_rd_idx;
        r_prod     <= n_prod;
        r_status   <= n_status;
        r_addr_out <= n_addr_out;
        r_free_out <= n_free_out;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_slot_address = r_addr_out;
    assign o_free_slots   = r_free_out;

    // every command ends back in idle with its result
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while a command is still in flight");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_strobe))
        else $error("accepted command neither in flight nor answered");

    // the new count is latched at the start of a rebuild, the stack only at its end
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_REB_DIV && r_state != S_REB_MUL) |->
            ((r_top <= r_active) && (r_lw <= r_active)))
        else $error("free stack depth or low-water mark past active count");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_FREE_DIV || r_state == S_REB_DIV))
        else $error("divider finished outside a divide state");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_top < r_active))
        else $error("stack push beyond active slot count");

endmodule

/* src/fspa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/fspa_div.sv */
// Restoring divider, one quotient bit per cycle.
// Needs i_num < i_den * 2**Q_W. No dependencies.
`timescale 1ns / 1ps

module fspa_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16,
    localparam int SH_W  = DEN_W + Q_W,
    localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W,
    localparam int CW    = $clog2(Q_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo,
    output logic [DEN_W-1:0] o_rem
);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [SH_W-1:0]  r_den_sh;
    logic [Q_W-1:0]   r_quo;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_ext;
    logic             ge;

    assign rem_ext = CMP_W'(r_rem);
    assign den_ext = CMP_W'(r_den_sh);
    assign ge      = (rem_ext >= den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= i_num;
            r_den_sh <= SH_W'(i_den) << (Q_W - 1);
            r_quo    <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= NUM_W'(rem_ext - den_ext);
            end
            r_quo    <= {r_quo[Q_W-2:0], ge};
            r_den_sh <= r_den_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DEN_W-1:0];

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for fixed_slot_pool_allocator: directed and random
// command words checked against an in-bench model of the LIFO free-slot pool.
// Depends on fspa_pkg and the fixed_slot_pool_allocator RTL.
`timescale 1ns / 1ps

module tb_top;
    import fspa_pkg::*;

    localparam int POOL_MAX   = DEF_MAX_SLOTS;
    localparam int MIN_BYTES  = DEF_MIN_SLOT_BYTES;
    localparam int STALL_MAX  = 2000;   // cycles with no handshake before giving up
    localparam int PRINT_MAX  = 100;    // cap on printed mismatch lines
    localparam int RAND_PHASES = 14;
    localparam int PHASE_WORDS = 118;

    // one command word as queued for the driver
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
    } t_pool_cmd;

    // one expected result word; op is kept only for bookkeeping, not compared
    typedef struct packed {
        t_op               op;
        t_status           status;
        logic [ADDR_W-1:0] slot_address;
        logic [FREE_W-1:0] free_slots;
    } t_pool_answer;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_op = '0;
    logic [ADDR_W-1:0]     i_free_address = '0;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_slot_address;
    logic [FREE_W-1:0]     o_free_slots;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // register shadows, as last written
    logic [ADDR_W-1:0]  cfg_base;
    logic [OBJ_W-1:0]   cfg_obj;
    logic [ALIGN_W-1:0] cfg_align;
    logic [COUNT_W-1:0] cfg_count;

    // pool model: size and count are latched at rebuild, base is used live
    int free_index_stack [POOL_MAX];
    int free_depth;
    int slot_bytes;
    int pool_slots;

    t_pool_cmd          pending_cmds [$];
    t_pool_answer       expected_answers [$];
    logic [ADDR_W-1:0]  live_addrs [$];     // slots handed out and not yet freed

    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_wait = 0;
    int steady_left = 0;

    // driver scratch
    logic      word_taken;
    int        gap_now;
    t_pool_cmd next_cmd;

    // monitor scratch
    t_pool_answer want;

    fixed_slot_pool_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_free_address (i_free_address),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_slot_address (o_slot_address),
        .o_free_slots   (o_free_slots),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // Slot size = max(object, minimum), rounded up to the alignment (0 = none).
    // Count is clamped to the pool depth; stack refilled so that pops come
    // out count-1, count-2, ... 0.
    function automatic void rebuild_pool_model();
        int size;
        size = (int'(cfg_obj) > MIN_BYTES) ? int'(cfg_obj) : MIN_BYTES;
        if (cfg_align != 0 && (size % int'(cfg_align)) != 0)
            size += int'(cfg_align) - (size % int'(cfg_align));
        slot_bytes = size;
        pool_slots = (int'(cfg_count) > POOL_MAX) ? POOL_MAX : int'(cfg_count);
        for (int k = 0; k < POOL_MAX; k++)
            free_index_stack[k] = (k < pool_slots) ? k : 0;
        free_depth = pool_slots;
    endfunction

    function automatic void reset_pool_model();
        cfg_base  = ADDR_W'(RST_BASE);
        cfg_obj   = OBJ_W'(RST_OBJ);
        cfg_align = ALIGN_W'(RST_ALIGN);
        cfg_count = COUNT_W'(RST_COUNT);
        rebuild_pool_model();
    endfunction

    // Work out the answer to one accepted word and queue it.
    function automatic void predict_pool_answer(input t_op op, input logic [ADDR_W-1:0] addr);
        t_pool_answer ans;
        logic [63:0]  offset;
        logic [63:0]  span;
        logic [63:0]  sum;
        int           idx;
        ans.op           = op;
        ans.status       = ST_OK;
        ans.slot_address = '0;
        case (op)
            OP_ALLOC: begin
                if (free_depth == 0) begin
                    ans.status = ST_EXHAUSTED;
                end else begin
                    free_depth--;
                    idx = free_index_stack[free_depth];
                    // wraps at the address width
                    sum = 64'(cfg_base) + 64'(idx) * 64'(slot_bytes);
                    ans.slot_address = sum[ADDR_W-1:0];
                end
            end
            OP_FREE: begin
                span   = 64'(slot_bytes) * 64'(pool_slots);
                offset = 64'(addr) - 64'(cfg_base);
                if (addr == '0)
                    ans.status = ST_NULL;
                else if (addr < cfg_base || offset >= span)
                    ans.status = ST_OUT_OF_POOL;
                else if ((offset % 64'(slot_bytes)) != 0)
                    ans.status = ST_MISALIGNED;
                else if (free_depth >= pool_slots)
                    ans.status = ST_DOUBLE_FREE;
                else begin
                    free_index_stack[free_depth] = int'(offset / 64'(slot_bytes));
                    free_depth++;
                end
            end
            OP_REBUILD: rebuild_pool_model();
            default: ;  // no-op word: ok, nothing changes
        endcase
        ans.free_slots = FREE_W'(free_depth);
        expected_answers.push_back(ans);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] exp_val);
        if (mismatch_count < PRINT_MAX)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    // Gap before the next word: often none, else a random wait, with
    // occasional back-to-back stretches.
    function automatic int draw_send_gap();
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    // Driver: a word is taken at an edge with start high and busy low. start
    // stays high across back-to-back words, so it gets one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            send_wait <= 0;
        end else begin
            word_taken = start && !busy;
            if (word_taken)
                predict_pool_answer(t_op'(i_op), i_free_address);
            if (word_taken || !start) begin
                gap_now = word_taken ? draw_send_gap() : send_wait;
                if (gap_now == 0 && pending_cmds.size() != 0) begin
                    next_cmd       = pending_cmds.pop_front();
                    start          <= 1'b1;
                    i_op           <= next_cmd.op;
                    i_free_address <= next_cmd.addr;
                end else begin
                    start     <= 1'b0;
                    send_wait <= (gap_now == 0) ? 0 : gap_now - 1;
                end
            end
        end
    end

    // Monitor: every strobe is matched against the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("result word with nothing pending", o_slot_address, '0);
            end else begin
                want = expected_answers.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", ADDR_W'(o_status), ADDR_W'(want.status));
                if (o_slot_address !== want.slot_address)
                    report_mismatch("slot address", o_slot_address, want.slot_address);
                if (o_free_slots !== want.free_slots)
                    report_mismatch("free slots", ADDR_W'(o_free_slots),
                                    ADDR_W'(want.free_slots));
                // keep the list of handed-out slots for well-formed frees
                if (want.op == OP_ALLOC && want.status == ST_OK)
                    live_addrs.push_back(want.slot_address);
                else if (want.op == OP_REBUILD)
                    live_addrs.delete();
            end
        end
    end

    // Watchdog: no word taken and no result for too long ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_cmd(input t_op op, input logic [ADDR_W-1:0] addr);
        t_pool_cmd cmd;
        cmd.op   = op;
        cmd.addr = addr;
        pending_cmds.push_back(cmd);
    endtask

    // Sender pause: nothing queued, nothing on the port, nothing outstanding.
    task automatic drain_pool();
        while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_BASE:  cfg_base  = value[ADDR_W-1:0];
            CFG_OBJ:   cfg_obj   = value[OBJ_W-1:0];
            CFG_ALIGN: cfg_align = value[ALIGN_W-1:0];
            CFG_COUNT: cfg_count = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // New pool settings; they only bite at the next rebuild (base is live).
    task automatic set_pool(input logic [31:0] base, input int obj, input int align,
                            input int count);
        drain_pool();
        write_reg(CFG_BASE, base);
        write_reg(CFG_OBJ, CFG_DATA_W'(obj));
        write_reg(CFG_ALIGN, CFG_DATA_W'(align));
        write_reg(CFG_COUNT, CFG_DATA_W'(count));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Free address: mostly a slot really handed out, else null, random,
    // below base, off a slot boundary, or a slot index that may be free already.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        logic [ADDR_W-1:0] a;
        int                k;
        k = $urandom_range(0, pool_slots);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                if (live_addrs.size() != 0) begin
                    k = $urandom_range(0, live_addrs.size() - 1);
                    a = live_addrs[k];
                    live_addrs.delete(k);
                end else begin
                    a = cfg_base + ADDR_W'(k) * ADDR_W'(slot_bytes);
                end
            end
            6: a = '0;
            7: a = ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom)
                                              : cfg_base - ADDR_W'($urandom_range(1, 64));
            8: a = cfg_base + ADDR_W'(k) * ADDR_W'(slot_bytes) + ADDR_W'($urandom_range(1, 7));
            default: a = cfg_base + ADDR_W'(k) * ADDR_W'(slot_bytes);
        endcase
        return a;
    endfunction

    // Random word, generated only when the driver's queue is empty so that
    // frees can use slots that came back in earlier results.
    task automatic push_random_cmd();
        int pick;
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        pick = $urandom_range(0, 99);
        if (pick < 46)
            push_cmd(OP_ALLOC, ADDR_W'($urandom));
        else if (pick < 92)
            push_cmd(OP_FREE, pick_free_address());
        else if (pick < 96)
            push_cmd(OP_REBUILD, ADDR_W'($urandom));
        else
            push_cmd(OP_NOP, ADDR_W'($urandom));
    endtask

    initial begin
        logic [31:0] base;
        int          obj;
        int          align;
        int          count;

        reset_pool_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset pool: base 4096, 16-byte slots, 256 slots, all free.
        push_cmd(OP_FREE, 32'd4096);                    // stack full -> double free
        push_cmd(OP_ALLOC, '0);                         // top slot 255
        push_cmd(OP_FREE, '0);                          // null
        push_cmd(OP_FREE, 32'd4095);                    // just below base
        push_cmd(OP_FREE, 32'd4096 + 32'd256 * 32'd16); // one past the end
        push_cmd(OP_FREE, 32'hFFFF_FFFF);               // far outside
        push_cmd(OP_FREE, 32'd4097);                    // off a slot boundary
        push_cmd(OP_FREE, 32'd4096 + 32'd255 * 32'd16); // good free
        push_cmd(OP_NOP, 32'hFFFF_FFFF);
        push_cmd(OP_REBUILD, '0);

        // Top base, object 1 (min size 8), no alignment, 4 slots. The first
        // alloc still uses the old size/count with the new base: wraps.
        set_pool(32'hFFFF_FFFF, 1, 0, 4);
        push_cmd(OP_ALLOC, '0);
        push_cmd(OP_REBUILD, '0);
        repeat (5) push_cmd(OP_ALLOC, '0);              // last one exhausted
        push_cmd(OP_FREE, 32'hFFFF_FFFF);               // slot 0

        // Largest slots: 65535 aligned to 4096 -> 65536 bytes.
        set_pool(32'd1, 65535, 4096, 256);
        push_cmd(OP_REBUILD, '0);
        push_cmd(OP_ALLOC, '0);
        push_cmd(OP_FREE, 32'd1 + 32'd255 * 32'd65536);

        // Empty pool.
        set_pool(32'd4096, 10, 3, 0);
        push_cmd(OP_REBUILD, '0);
        push_cmd(OP_ALLOC, '0);
        push_cmd(OP_FREE, 32'd4096);

        // Count above the pool depth clamps to it.
        set_pool(32'h8000_0000, 8, 1, 511);
        push_cmd(OP_REBUILD, '0);
        push_cmd(OP_ALLOC, '0);

        // Random phases: mostly small pools so exhaustion and double frees
        // are reached often, with odd alignments and the odd large pool.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       base = $urandom;
                1:       base = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
                default: base = $urandom_range(1, 32'h00FF_FFFF);
            endcase
            if (base == '0)
                base = 32'd1;
            obj = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535)
                                              : $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0:       align = 0;
                1:       align = 1;
                2:       align = 1 << $urandom_range(0, 12);
                3:       align = $urandom_range(0, 4096);
                4:       align = 4096;
                default: align = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 19))
                0:       count = 0;
                1, 2, 3: count = $urandom_range(13, 256);
                4, 5:    count = $urandom_range(257, 511);
                default: count = $urandom_range(1, 12);
            endcase
            set_pool(base, obj, align, count);
            repeat ($urandom_range(0, 2)) push_random_cmd();   // still on old settings
            push_cmd(OP_REBUILD, '0);
            repeat (PHASE_WORDS) begin
                if ($urandom_range(0, 99) == 0)
                    drain_pool();
                push_random_cmd();
            end
        end

        drain_pool();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* fixed_slot_pool_allocator.f */
src/fspa_pkg.sv
src/fspa_ram.sv
src/fspa_div.sv
src/fixed_slot_pool_allocator.sv
tb/tb_top.sv
